FILE: hdl/tehp_pkg.sv
// Package for the tag extended header parser.
// Holds the parse phase and status codes, queue item and result types.
// No dependencies.
`default_nettype none

package tehp_pkg;

  localparam int unsigned TEHP_QUEUE_DEPTH = 4;
  localparam int unsigned TEHP_SIZE_W      = 28;
  localparam int unsigned TEHP_CRC_W       = 35;
  localparam logic [3:0]  TEHP_HEAD_BYTES  = 4'd6;
  localparam logic [3:0]  TEHP_SIZE_BYTES  = 4'd4;
  localparam logic [3:0]  TEHP_CRC_END     = 4'd11;
  localparam logic [7:0]  TEHP_UPD_LEN     = 8'd0;
  localparam logic [7:0]  TEHP_CRC_LEN     = 8'd5;
  localparam logic [7:0]  TEHP_RES_LEN     = 8'd1;

  typedef enum logic [2:0] {
    PH_UPD_LEN  = 3'd0,
    PH_CRC_LEN  = 3'd1,
    PH_CRC_DATA = 3'd2,
    PH_RES_LEN  = 3'd3,
    PH_RES_DATA = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SIZE_SMALL = 3'd1,
    ST_SIZE_MISM  = 3'd2,
    ST_BAD_UPD    = 3'd3,
    ST_BAD_CRC    = 3'd4,
    ST_BAD_RES    = 3'd5
  } status_t;

  // one queued byte with its precomputed class bits
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       len_upd_ok;
    logic       len_crc_ok;
    logic       len_res_ok;
  } tehp_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [TEHP_SIZE_W-1:0] header_size;
    logic                   update_flag;
    logic                   crc_present;
    logic                   restrict_present;
    logic [TEHP_CRC_W-1:0]  crc_value;
    logic [1:0]             tag_size_limit;
    logic                   text_encoding_limit;
    logic [1:0]             text_size_limit;
    logic                   image_encoding_limit;
    logic [1:0]             image_size_limit;
  } tehp_result_t;

  // flags: bit0 update, bit1 crc, bit2 restrictions
  function automatic phase_t tehp_pick(input phase_t from, input logic [2:0] flags);
    phase_t ph;
    ph = PH_DONE;
    if (from <= PH_RES_LEN && flags[2]) ph = PH_RES_LEN;
    if (from <= PH_CRC_LEN && flags[1]) ph = PH_CRC_LEN;
    if (from <= PH_UPD_LEN && flags[0]) ph = PH_UPD_LEN;
    return ph;
  endfunction

  function automatic logic [3:0] tehp_expect(input logic [2:0] flags);
    logic [3:0] e;
    e = 4'd6 + {3'd0, flags[0]} + (flags[1] ? 4'd6 : 4'd0) + (flags[2] ? 4'd2 : 4'd0);
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tehp_if.sv
// Stream interfaces of the tag extended header parser: byte input, result output.
// Depends on tehp_pkg.
`default_nettype none

interface tehp_in_if;
  import tehp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       header_start;

  modport source (output valid, output data_byte, output header_start, input ready);
  modport sink   (input valid, input data_byte, input header_start, output ready);
endinterface

interface tehp_out_if;
  import tehp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [TEHP_SIZE_W-1:0] header_size;
  logic                   update_flag;
  logic                   crc_present;
  logic                   restrict_present;
  logic [TEHP_CRC_W-1:0]  crc_value;
  logic [1:0]             tag_size_limit;
  logic                   text_encoding_limit;
  logic [1:0]             text_size_limit;
  logic                   image_encoding_limit;
  logic [1:0]             image_size_limit;

  modport source (output valid, output status, output header_size, output update_flag,
                  output crc_present, output restrict_present, output crc_value,
                  output tag_size_limit, output text_encoding_limit,
                  output text_size_limit, output image_encoding_limit,
                  output image_size_limit, input ready);
  modport sink   (input valid, input status, input header_size, input update_flag,
                  input crc_present, input restrict_present, input crc_value,
                  input tag_size_limit, input text_encoding_limit,
                  input text_size_limit, input image_encoding_limit,
                  input image_size_limit, output ready);
endinterface

`default_nettype wire

FILE: hdl/tehp_front.sv
// Front end: accepts input bytes and classifies them for the queue.
// Depends on tehp_pkg and tehp_in_if.
`default_nettype none

module tehp_front (
  tehp_in_if.sink               in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output tehp_pkg::tehp_item_t  q_item
);
  import tehp_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.start      = in_ch.header_start;
    q_item.data       = in_ch.data_byte;
    q_item.len_upd_ok = (in_ch.data_byte == TEHP_UPD_LEN);
    q_item.len_crc_ok = (in_ch.data_byte == TEHP_CRC_LEN);
    q_item.len_res_ok = (in_ch.data_byte == TEHP_RES_LEN);
  end

endmodule

`default_nettype wire

FILE: hdl/tehp_queue.sv
// Short FIFO between front and back ends of the parser.
// Depends on tehp_pkg.
`default_nettype none

module tehp_queue #(
  parameter int unsigned DEPTH = tehp_pkg::TEHP_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  tehp_pkg::tehp_item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output tehp_pkg::tehp_item_t  head_item
);
  import tehp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tehp_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tehp_back.sv
// Back end: header parse state machine and output result register.
// Depends on tehp_pkg and tehp_out_if.
`default_nettype none

module tehp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  tehp_pkg::tehp_item_t  q_item,
  output logic                  q_pop,
  tehp_out_if.source            out_ch
);
  import tehp_pkg::*;

  phase_t                 ph_r, ph_nxt;
  logic [3:0]             idx_r, idx_nxt;
  logic                   act_r, act_nxt;
  logic [TEHP_SIZE_W-1:0] size_r, size_nxt;
  logic [2:0]             flg_r, flg_nxt;
  logic [TEHP_CRC_W-1:0]  crc_r, crc_nxt;
  logic                   out_vld_r, out_vld_nxt;
  tehp_result_t           res_r, res_nxt;

  logic                   emit;
  logic                   show_flags;
  logic                   have_res;
  logic                   chk_done;
  status_t                st;
  logic [3:0]             idx_in;
  logic [2:0]             flg_sh;
  logic [7:0]             rb;

  assign q_pop = q_not_empty && (!out_vld_r || out_ch.ready);

  always_comb begin
    ph_nxt     = ph_r;
    idx_nxt    = idx_r;
    act_nxt    = act_r;
    size_nxt   = size_r;
    flg_nxt    = flg_r;
    crc_nxt    = crc_r;
    emit       = 1'b0;
    show_flags = 1'b1;
    have_res   = 1'b0;
    chk_done   = 1'b0;
    st         = ST_OK;
    idx_in     = idx_r;
    if (q_pop) begin
      if (q_item.start) begin
        ph_nxt   = PH_UPD_LEN;
        idx_nxt  = '0;
        size_nxt = '0;
        flg_nxt  = '0;
        crc_nxt  = '0;
        act_nxt  = 1'b1;
      end
      if (act_nxt) begin
        if (idx_nxt < TEHP_HEAD_BYTES) begin
          idx_in  = idx_nxt;
          idx_nxt = idx_nxt + 4'd1;
          if (idx_in < TEHP_SIZE_BYTES) begin
            size_nxt = {size_nxt[TEHP_SIZE_W-8:0], q_item.data[6:0]};
          end else if (idx_in == TEHP_SIZE_BYTES) begin
            // flag-byte count, skipped
          end else if (size_nxt < TEHP_SIZE_W'(TEHP_HEAD_BYTES)) begin
            emit       = 1'b1;
            st         = ST_SIZE_SMALL;
            show_flags = 1'b0;
          end else begin
            flg_nxt = {q_item.data[4], q_item.data[5], q_item.data[6]};
            if (size_nxt != TEHP_SIZE_W'(tehp_expect(flg_nxt))) begin
              emit = 1'b1;
              st   = ST_SIZE_MISM;
            end else begin
              ph_nxt = tehp_pick(PH_UPD_LEN, flg_nxt);
              if (ph_nxt == PH_DONE) begin
                emit = 1'b1;
              end else begin
                idx_nxt = TEHP_HEAD_BYTES;
              end
            end
          end
        end else begin
          unique case (ph_r)
            PH_UPD_LEN: begin
              if (!q_item.len_upd_ok) begin
                emit = 1'b1;
                st   = ST_BAD_UPD;
              end else begin
                ph_nxt   = tehp_pick(PH_CRC_LEN, flg_r);
                chk_done = 1'b1;
              end
            end
            PH_CRC_LEN: begin
              if (!q_item.len_crc_ok) begin
                emit = 1'b1;
                st   = ST_BAD_CRC;
              end else begin
                ph_nxt  = PH_CRC_DATA;
                idx_nxt = TEHP_HEAD_BYTES;
              end
            end
            PH_CRC_DATA: begin
              crc_nxt = {crc_r[TEHP_CRC_W-8:0], q_item.data[6:0]};
              idx_nxt = idx_r + 4'd1;
              if (idx_nxt >= TEHP_CRC_END) begin
                idx_nxt  = TEHP_HEAD_BYTES;
                ph_nxt   = tehp_pick(PH_RES_LEN, flg_r);
                chk_done = 1'b1;
              end
            end
            PH_RES_LEN: begin
              if (!q_item.len_res_ok) begin
                emit = 1'b1;
                st   = ST_BAD_RES;
              end else begin
                ph_nxt = PH_RES_DATA;
              end
            end
            PH_RES_DATA: begin
              emit     = 1'b1;
              have_res = 1'b1;
            end
            default: begin
              ph_nxt   = PH_DONE;
              chk_done = 1'b1;
            end
          endcase
          if (chk_done && ph_nxt == PH_DONE) begin
            emit = 1'b1;
          end
        end
      end
      if (emit) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    flg_sh      = show_flags ? flg_nxt : 3'd0;
    rb          = have_res ? q_item.data : 8'd0;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    res_nxt     = res_r;
    if (emit) begin
      out_vld_nxt                  = 1'b1;
      res_nxt.status               = st;
      res_nxt.header_size          = size_nxt;
      res_nxt.update_flag          = flg_sh[0];
      res_nxt.crc_present          = flg_sh[1];
      res_nxt.restrict_present     = flg_sh[2];
      res_nxt.crc_value            = crc_nxt;
      res_nxt.tag_size_limit       = rb[7:6];
      res_nxt.text_encoding_limit  = rb[5];
      res_nxt.text_size_limit      = rb[4:3];
      res_nxt.image_encoding_limit = rb[2];
      res_nxt.image_size_limit     = rb[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_UPD_LEN;
      idx_r     <= '0;
      act_r     <= 1'b0;
      size_r    <= '0;
      flg_r     <= '0;
      crc_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      ph_r      <= ph_nxt;
      idx_r     <= idx_nxt;
      act_r     <= act_nxt;
      size_r    <= size_nxt;
      flg_r     <= flg_nxt;
      crc_r     <= crc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid                = out_vld_r;
  assign out_ch.status               = res_r.status;
  assign out_ch.header_size          = res_r.header_size;
  assign out_ch.update_flag          = res_r.update_flag;
  assign out_ch.crc_present          = res_r.crc_present;
  assign out_ch.restrict_present     = res_r.restrict_present;
  assign out_ch.crc_value            = res_r.crc_value;
  assign out_ch.tag_size_limit       = res_r.tag_size_limit;
  assign out_ch.text_encoding_limit  = res_r.text_encoding_limit;
  assign out_ch.text_size_limit      = res_r.text_size_limit;
  assign out_ch.image_encoding_limit = res_r.image_encoding_limit;
  assign out_ch.image_size_limit     = res_r.image_size_limit;

endmodule

`default_nettype wire

FILE: hdl/tag_extended_header_parser.sv
// Tag extended header parser, top level: front end, byte queue, parse back end.
// Throughput: one byte per cycle while no result waits for out_ch.ready.
// The result of the byte that completes or fails a header is registered on out_ch.
// Reset: synchronous active-low rst_n empties the queue, idles the parser and
// clears the output valid. Depends on tehp_pkg, tehp_if, tehp_front/queue/back.
`default_nettype none

module tag_extended_header_parser #(
  parameter int unsigned QUEUE_DEPTH = tehp_pkg::TEHP_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tehp_in_if.sink    in_ch,
  tehp_out_if.source out_ch
);
  import tehp_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  tehp_item_t q_in_item;
  tehp_item_t q_head_item;

  tehp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in_item)
  );

  tehp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  tehp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_head_item),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: sim/tehp_header_checker.sv
// Checker for the tag extended header parser: watches both stream channels,
// decodes every accepted byte into awaited results and compares each transfer.
// Depends on tehp_pkg and tehp_if.
module tehp_header_checker
  import tehp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tehp_in_if   in_mon,
  tehp_out_if  out_mon,
  output int   mismatches,
  output int   pending,
  output int   results_ok,
  output int   results_err
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [3:0]   byte_idx;
  logic         active;
  logic [27:0]  size_acc;
  logic [2:0]   flags;      // bit0 update, bit1 crc, bit2 restrictions
  logic [34:0]  crc_acc;
  phase_t       phase;
  tehp_result_t awaited_results[$];
  tehp_result_t want;

  function automatic void clear_decoder();
    byte_idx = '0;
    active   = 1'b0;
    size_acc = '0;
    flags    = '0;
    crc_acc  = '0;
    phase    = PH_UPD_LEN;
  endfunction

  function automatic phase_t next_field(input phase_t from);
    if (from <= PH_UPD_LEN && flags[0]) return PH_UPD_LEN;
    if (from <= PH_CRC_LEN && flags[1]) return PH_CRC_LEN;
    if (from <= PH_RES_LEN && flags[2]) return PH_RES_LEN;
    return PH_DONE;
  endfunction

  function automatic void post_result(input status_t st, input logic show_flags,
                                      input logic have_res, input logic [7:0] rb);
    tehp_result_t r;
    logic [2:0]   fl;
    fl = show_flags ? flags : 3'b000;
    if (!have_res) rb = '0;
    r.status               = st;
    r.header_size          = size_acc;
    r.update_flag          = fl[0];
    r.crc_present          = fl[1];
    r.restrict_present     = fl[2];
    r.crc_value            = crc_acc;
    r.tag_size_limit       = rb[7:6];
    r.text_encoding_limit  = rb[5];
    r.text_size_limit      = rb[4:3];
    r.image_encoding_limit = rb[2];
    r.image_size_limit     = rb[1:0];
    awaited_results.push_back(r);
    active = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [3:0] idx;
    logic [3:0] need;
    if (start) begin
      clear_decoder();
      active = 1'b1;
    end
    if (!active) return;

    if (byte_idx < TEHP_HEAD_BYTES) begin
      idx      = byte_idx;
      byte_idx = idx + 4'd1;
      if (idx < TEHP_SIZE_BYTES) begin
        size_acc = {size_acc[20:0], b[6:0]};
        return;
      end
      if (idx == TEHP_SIZE_BYTES) return;  // flag-byte count, ignored
      if (size_acc < 28'd6) begin
        post_result(ST_SIZE_SMALL, 1'b0, 1'b0, 8'h00);
        return;
      end
      flags = {b[4], b[5], b[6]};
      need  = 4'd6 + {3'd0, flags[0]} + (flags[1] ? 4'd6 : 4'd0) + (flags[2] ? 4'd2 : 4'd0);
      if (size_acc != {24'd0, need}) begin
        post_result(ST_SIZE_MISM, 1'b1, 1'b0, 8'h00);
        return;
      end
      phase = next_field(PH_UPD_LEN);
      if (phase == PH_DONE) post_result(ST_OK, 1'b1, 1'b0, 8'h00);
      return;
    end

    case (phase)
      PH_UPD_LEN: begin
        if (b != TEHP_UPD_LEN) begin
          post_result(ST_BAD_UPD, 1'b1, 1'b0, 8'h00);
          return;
        end
        phase = next_field(PH_CRC_LEN);
      end
      PH_CRC_LEN: begin
        if (b != TEHP_CRC_LEN) begin
          post_result(ST_BAD_CRC, 1'b1, 1'b0, 8'h00);
          return;
        end
        phase    = PH_CRC_DATA;
        byte_idx = TEHP_HEAD_BYTES;
        return;
      end
      PH_CRC_DATA: begin
        crc_acc  = {crc_acc[27:0], b[6:0]};
        byte_idx = byte_idx + 4'd1;
        if (byte_idx < TEHP_CRC_END) return;
        byte_idx = TEHP_HEAD_BYTES;
        phase    = next_field(PH_RES_LEN);
      end
      PH_RES_LEN: begin
        if (b != TEHP_RES_LEN) begin
          post_result(ST_BAD_RES, 1'b1, 1'b0, 8'h00);
          return;
        end
        phase = PH_RES_DATA;
        return;
      end
      PH_RES_DATA: begin
        post_result(ST_OK, 1'b1, 1'b1, b);
        return;
      end
      default: phase = PH_DONE;
    endcase
    if (phase == PH_DONE) post_result(ST_OK, 1'b1, 1'b0, 8'h00);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
    end else begin
      // results leave for bytes accepted earlier, so compare before decoding
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no result awaited (status 0x%0h)", out_mon.status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("header_size", want.header_size, out_mon.header_size);
          check_field("update_flag", want.update_flag, out_mon.update_flag);
          check_field("crc_present", want.crc_present, out_mon.crc_present);
          check_field("restrict_present", want.restrict_present, out_mon.restrict_present);
          check_field("crc_value", want.crc_value, out_mon.crc_value);
          check_field("tag_size_limit", want.tag_size_limit, out_mon.tag_size_limit);
          check_field("text_encoding_limit", want.text_encoding_limit,
                      out_mon.text_encoding_limit);
          check_field("text_size_limit", want.text_size_limit, out_mon.text_size_limit);
          check_field("image_encoding_limit", want.image_encoding_limit,
                      out_mon.image_encoding_limit);
          check_field("image_size_limit", want.image_size_limit, out_mon.image_size_limit);
          if (want.status == ST_OK) results_ok++;
          else results_err++;
        end
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.data_byte, in_mon.header_start);
      pending = awaited_results.size();
    end
  end

endmodule

FILE: sim/tb_tag_extended_header_parser.sv
// Testbench top for the tag extended header parser: clock, reset, byte stimulus,
// result back-pressure, stall watchdog and verdict.
// Depends on tehp_pkg, tehp_if, the parser RTL and tehp_header_checker.
module tb_tag_extended_header_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import tehp_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam int FULL_HEADER  = 64;
  localparam int PHASE_BYTES  = 90;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   bytes_sent;
  int   headers_sent;
  int   stall_cycles;
  int   mismatches;
  int   pending;
  int   results_ok;
  int   results_err;

  tehp_in_if  in_ch ();
  tehp_out_if out_ch ();

  tag_extended_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tehp_header_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_ok  (results_ok),
    .results_err (results_err)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles with %0d results awaited", stall_cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic coin();
    logic b;
    b = 1'($urandom_range(1));
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.header_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // lays out size, count, flags and the optional fields; cut limits the bytes sent
  task automatic send_header(input logic [27:0] size, input logic [7:0] flag_byte,
                             input logic [7:0] upd_len, input logic [7:0] crc_len,
                             input logic [34:0] crc, input logic [7:0] res_len,
                             input logic [7:0] res_byte, input int cut);
    logic [7:0] seq[$];
    logic [7:0] cnt;
    cnt = 8'($urandom_range(255));
    seq = {};
    seq.push_back({coin(), size[27:21]});
    seq.push_back({coin(), size[20:14]});
    seq.push_back({coin(), size[13:7]});
    seq.push_back({coin(), size[6:0]});
    seq.push_back(cnt);
    seq.push_back(flag_byte);
    if (flag_byte[6]) seq.push_back(upd_len);
    if (flag_byte[5]) begin
      seq.push_back(crc_len);
      for (int k = 4; k >= 0; k--) seq.push_back({coin(), crc[7*k +: 7]});
    end
    if (flag_byte[4]) begin
      seq.push_back(res_len);
      seq.push_back(res_byte);
    end
    headers_sent++;
    for (int k = 0; k < seq.size() && k < cut; k++) send_byte(seq[k], k == 0);
  endtask

  task automatic random_header();
    int          kind;
    int          n;
    logic        u, c, r;
    logic [3:0]  low_bits;
    logic [27:0] size;
    logic [7:0]  flag_byte, upd_len, crc_len, res_len, res_byte;
    logic [34:0] crc;
    int          cut;
    kind     = $urandom_range(99);
    u        = coin();
    c        = coin();
    r        = coin();
    if (kind >= 22 && kind < 26) u = 1'b1;
    if (kind >= 26 && kind < 34) c = 1'b1;
    if (kind >= 30 && kind < 38) r = 1'b1;
    low_bits  = 4'($urandom_range(15));
    flag_byte = {coin(), u, c, r, low_bits};
    size      = 28'd6 + {27'd0, u} + (c ? 28'd6 : 28'd0) + (r ? 28'd2 : 28'd0);
    upd_len   = TEHP_UPD_LEN;
    crc_len   = TEHP_CRC_LEN;
    res_len   = TEHP_RES_LEN;
    crc       = 35'({$urandom, $urandom});
    res_byte  = 8'($urandom_range(255));
    cut       = FULL_HEADER;
    if (kind < 8) begin
      size = 28'($urandom_range(5));
    end else if (kind < 14) begin
      size = 28'($urandom);
    end else if (kind < 22) begin
      size = size ^ (28'd1 << $urandom_range(3));
    end else if (kind < 26) begin
      upd_len = 8'($urandom_range(1, 255));
    end else if (kind < 30) begin
      crc_len = 8'($urandom_range(255));
      if (crc_len == TEHP_CRC_LEN) crc_len = 8'hFA;
    end else if (kind < 38) begin
      res_len = 8'($urandom_range(255));
      if (res_len == TEHP_RES_LEN) res_len = 8'h00;
    end else if (kind < 46) begin
      cut = $urandom_range(1, 18);
    end

    if (kind >= 94) begin
      n = $urandom_range(1, 20);
      headers_sent++;
      for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), k == 0);
    end else if (kind >= 88) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      send_header(size, flag_byte, upd_len, crc_len, crc, res_len, res_byte, cut);
    end
  endtask

  task automatic run_random(input int src_pct, input int snk_pct, input logic pause_once);
    int goal;
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    goal          = bytes_sent + PHASE_BYTES;
    while (bytes_sent < goal) begin
      random_header();
      if (pause_once && bytes_sent >= goal - PHASE_BYTES / 2) begin
        hold_until_drained();
        pause_once = 1'b0;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.header_start = 1'b0;
    out_ch.ready       = 1'b0;
    src_idle_pct       = 15;
    sink_idle_pct      = 50;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle bytes, size checks, each length error, full header, restart
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_header(28'd0, 8'hFF, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd5, 8'h00, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd6, 8'h8F, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'hFFFFFFF, 8'h00, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd15, 8'h70, TEHP_UPD_LEN, TEHP_CRC_LEN, 35'h7FFFFFFFF, TEHP_RES_LEN,
                8'hFF, FULL_HEADER);
    send_header(28'd15, 8'hFF, TEHP_UPD_LEN, TEHP_CRC_LEN, 35'd0, TEHP_RES_LEN,
                8'hA5, FULL_HEADER);
    send_header(28'd7, 8'h40, 8'hFF, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd7, 8'h40, TEHP_UPD_LEN, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd12, 8'h20, 8'd0, 8'd0, 35'h12345678, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd8, 8'h10, 8'd0, 8'd5, 35'd0, 8'hFE, 8'h5A, FULL_HEADER);
    send_header(28'd14, 8'h30, 8'd0, TEHP_CRC_LEN, 35'h5A5A5A5A5, 8'd0, 8'h00, FULL_HEADER);
    send_header(28'd13, 8'h20, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);
    send_header(28'd15, 8'h70, TEHP_UPD_LEN, TEHP_CRC_LEN, 35'h2AAAAAAAA, TEHP_RES_LEN,
                8'h33, 9);
    send_header(28'd6, 8'h00, 8'd0, 8'd5, 35'd0, 8'd1, 8'h00, FULL_HEADER);

    run_random(15, 50, 1'b1);
    run_random(50, 15, 1'b0);
    run_random(0, 0, 1'b0);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d header bytes over %0d headers under three idle mixes.",
             bytes_sent, headers_sent);
    $display("Results checked: %0d ok, %0d with an error status.", results_ok, results_err);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
